@@ rtl/tlm_pkg.sv @@
// Shared types, corner tables, latency figures and saturation helpers for the line tessellator
package tlm_pkg;

  // one input word: a segment with its neighbor points, widths and colors
  typedef struct packed {
    logic signed [15:0] before_x;
    logic signed [15:0] start_x;
    logic signed [15:0] end_x;
    logic signed [15:0] after_x;
    logic signed [15:0] before_y;
    logic signed [15:0] start_y;
    logic signed [15:0] end_y;
    logic signed [15:0] after_y;
    logic [15:0]        width_at_start;
    logic [15:0]        width_at_end;
    logic [23:0]        colour_at_start;
    logic [23:0]        colour_at_end;
  } in_word_t;

  // one output word: a single corner record
  typedef struct packed {
    logic signed [15:0] corner_x;
    logic signed [15:0] corner_y;
    logic signed [15:0] side_normal_x;
    logic signed [15:0] side_normal_y;
    logic signed [23:0] miter_x;
    logic signed [23:0] miter_y;
    logic [23:0]        corner_colour;
    logic [15:0]        corner_width;
    logic               last_corner;
  } out_word_t;

  localparam int NCORNER = 6;
  localparam logic [2:0] LAST_CORNER_IDX = 3'd5;
  // bit k: corner k sits on the end point
  localparam logic [NCORNER-1:0] AT_END   = 6'b011100;
  // bit k: corner k takes the negated normal and miter
  localparam logic [NCORNER-1:0] NEG_SIDE = 6'b110010;

  // pipeline depth of one unit vector unit
  function automatic int uv_lat(input int fb);
    return fb + 38;
  endfunction

  // pipeline depth of one miter unit
  function automatic int mt_lat(input int fb);
    return uv_lat(fb) + 30;
  endfunction

  // largest k <= 24 that keeps m2 * 4^k below 2^62
  function automatic logic [4:0] norm_shift(input logic [61:0] m2);
    logic [5:0] msb;
    logic [5:0] t;
    msb = '0;
    for (int i = 0; i < 62; i++) begin
      if (m2[i]) msb = 6'(i);
    end
    t = 6'd61 - msb;
    t = t >> 1;
    return (t > 6'd24) ? 5'd24 : t[4:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'sh7FFF;
    else if (v < -24'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    else if (v < -26'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

@@ rtl/tlm_delay.sv @@
// Enabled shift line that keeps side data aligned with the arithmetic pipeline
module tlm_delay #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [0:D-1];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[D-1];

endmodule

@@ rtl/tlm_unit_vec.sv @@
// Pipelined unit vector: squares, normalize shift, bit-serial root, restoring divides
module tlm_unit_vec import tlm_pkg::*; #(
  parameter int IW = 17,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] vx,
  input  logic signed [IW-1:0] vy,
  output logic signed [FB+1:0] ux,
  output logic signed [FB+1:0] uy
);

  localparam int PW  = 2 * IW;
  localparam int NSQ = 32;
  localparam int QW  = FB + 1;

  typedef struct packed {
    logic [4:0]    k;
    logic [IW-1:0] mx;
    logic [IW-1:0] my;
    logic          sx;
    logic          sy;
    logic          z;
  } side_t;

  logic signed [PW-1:0] sqx, sqy;
  logic [PW-1:0]        px_r, py_r;
  side_t                s0_r, s1_r, s1_nxt;
  logic [61:0]          m2, m2_r;

  logic [63:0] sq_n_r [0:NSQ];
  logic [63:0] sq_r_r [0:NSQ];
  side_t       sq_s_r [0:NSQ];

  logic [63:0]   dv_den_r [0:QW];
  logic [63:0]   dv_rx_r  [0:QW];
  logic [63:0]   dv_ry_r  [0:QW];
  logic [QW-1:0] dv_qx_r  [0:QW];
  logic [QW-1:0] dv_qy_r  [0:QW];
  side_t         dv_s_r   [0:QW];

  logic [31:0]          mag;
  logic signed [FB+1:0] qxs, qys;

  assign sqx = vx * vx;
  assign sqy = vy * vy;
  assign m2  = 62'(px_r) + 62'(py_r);
  assign mag = sq_r_r[NSQ][31:0];
  assign qxs = signed'((FB+2)'(dv_qx_r[QW]));
  assign qys = signed'((FB+2)'(dv_qy_r[QW]));

  // side data with normalize shift and zero flag
  always_comb begin
    s1_nxt   = s0_r;
    s1_nxt.k = norm_shift(m2);
    s1_nxt.z = (m2 == '0);
  end

  // squares, sum with normalize shift, scaled square
  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= sqx;
      py_r     <= sqy;
      s0_r.k   <= '0;
      s0_r.mx  <= vx[IW-1] ? IW'(-vx) : IW'(vx);
      s0_r.my  <= vy[IW-1] ? IW'(-vy) : IW'(vy);
      s0_r.sx  <= vx[IW-1];
      s0_r.sy  <= vy[IW-1];
      s0_r.z   <= 1'b0;
      m2_r     <= m2;
      s1_r     <= s1_nxt;
      sq_n_r[0] <= 64'(m2_r) << (2 * s1_r.k);
      sq_r_r[0] <= '0;
      sq_s_r[0] <= s1_r;
    end
  end

  // integer square root, one result bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSQ; j++) begin
        if (sq_n_r[j] >= sq_r_r[j] + (64'd1 << (2 * (NSQ - 1 - j)))) begin
          sq_n_r[j+1] <= sq_n_r[j] - (sq_r_r[j] + (64'd1 << (2 * (NSQ - 1 - j))));
          sq_r_r[j+1] <= (sq_r_r[j] >> 1) + (64'd1 << (2 * (NSQ - 1 - j)));
        end else begin
          sq_n_r[j+1] <= sq_n_r[j];
          sq_r_r[j+1] <= sq_r_r[j] >> 1;
        end
        sq_s_r[j+1] <= sq_s_r[j];
      end
    end
  end

  // rounded divide by the magnitude, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      dv_den_r[0] <= 64'(mag);
      dv_rx_r[0]  <= (64'(sq_s_r[NSQ].mx) << (FB + sq_s_r[NSQ].k)) + 64'(mag >> 1);
      dv_ry_r[0]  <= (64'(sq_s_r[NSQ].my) << (FB + sq_s_r[NSQ].k)) + 64'(mag >> 1);
      dv_qx_r[0]  <= '0;
      dv_qy_r[0]  <= '0;
      dv_s_r[0]   <= sq_s_r[NSQ];
      for (int t = 0; t < QW; t++) begin
        if (dv_rx_r[t] >= (dv_den_r[t] << (QW - 1 - t))) begin
          dv_rx_r[t+1] <= dv_rx_r[t] - (dv_den_r[t] << (QW - 1 - t));
          dv_qx_r[t+1] <= dv_qx_r[t] | (QW'(1) << (QW - 1 - t));
        end else begin
          dv_rx_r[t+1] <= dv_rx_r[t];
          dv_qx_r[t+1] <= dv_qx_r[t];
        end
        if (dv_ry_r[t] >= (dv_den_r[t] << (QW - 1 - t))) begin
          dv_ry_r[t+1] <= dv_ry_r[t] - (dv_den_r[t] << (QW - 1 - t));
          dv_qy_r[t+1] <= dv_qy_r[t] | (QW'(1) << (QW - 1 - t));
        end else begin
          dv_ry_r[t+1] <= dv_ry_r[t];
          dv_qy_r[t+1] <= dv_qy_r[t];
        end
        dv_den_r[t+1] <= dv_den_r[t];
        dv_s_r[t+1]   <= dv_s_r[t];
      end
    end
  end

  // sign and zero-vector override
  always_ff @(posedge clk) begin
    if (en) begin
      ux <= dv_s_r[QW].z ? '0 : (dv_s_r[QW].sx ? -qxs : qxs);
      uy <= dv_s_r[QW].z ? '0 : (dv_s_r[QW].sy ? -qys : qys);
    end
  end

endmodule

@@ rtl/tlm_miter.sv @@
// Pipelined miter: unit bisector, dot with outgoing normal, clamped restoring divide
module tlm_miter import tlm_pkg::*; #(
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [FB+1:0] ui_x,
  input  logic signed [FB+1:0] ui_y,
  input  logic signed [FB+1:0] uo_x,
  input  logic signed [FB+1:0] uo_y,
  output logic [23:0]          mag_x,
  output logic [23:0]          mag_y,
  output logic                 neg_x,
  output logic                 neg_y
);

  localparam int UW  = FB + 2;
  localparam int BW  = FB + 3;
  localparam int UL  = uv_lat(FB);
  localparam int PW  = 2 * UW;
  localparam int DTW = PW + 1;
  localparam int DW  = 3 * FB + 30;
  localparam int NIT = 24;

  typedef struct packed {
    logic          negx;
    logic          negy;
    logic          dz;
    logic          ovx;
    logic          ovy;
    logic [UW-1:0] nmx;
    logic [UW-1:0] nmy;
    logic          nnx;
    logic          nny;
  } mside_t;

  logic signed [BW-1:0]  bx_r, by_r;
  logic [2*UW-1:0]       uo_d;
  logic signed [UW-1:0]  uox_d, uoy_d, sx, sy, nx_c, ny_c;
  logic signed [PW-1:0]  prx, pry, prx_r, pry_r;
  logic signed [UW-1:0]  sx_p, sy_p, nx_p, ny_p, sx_d, sy_d, nx_d, ny_d;
  logic signed [DTW-1:0] dot_r;
  logic [DTW-1:0]        dmag;
  logic [UW-1:0]         asx, asy;
  mside_t                ms_n;

  logic [DW-1:0] dv_den_r [0:NIT];
  logic [DW-1:0] dv_rx_r  [0:NIT];
  logic [DW-1:0] dv_ry_r  [0:NIT];
  logic [23:0]   dv_qx_r  [0:NIT];
  logic [23:0]   dv_qy_r  [0:NIT];
  mside_t        dv_s_r   [0:NIT];
  logic [DW-1:0] nrx_r, nry_r, nden_r;
  mside_t        ns_r, ns_nxt;

  // incoming minus outgoing direction
  always_ff @(posedge clk) begin
    if (en) begin
      bx_r <= BW'(ui_x) - BW'(uo_x);
      by_r <= BW'(ui_y) - BW'(uo_y);
    end
  end

  tlm_unit_vec #(.IW(BW), .FB(FB)) u_bis (
    .clk (clk),
    .en  (en),
    .vx  (bx_r),
    .vy  (by_r),
    .ux  (sx),
    .uy  (sy)
  );

  // outgoing direction held until the bisector is ready
  tlm_delay #(.W(2 * UW), .D(1 + UL)) u_uo_dly (
    .clk (clk),
    .en  (en),
    .d   ({uo_x, uo_y}),
    .q   (uo_d)
  );

  assign uox_d = signed'(uo_d[2*UW-1:UW]);
  assign uoy_d = signed'(uo_d[UW-1:0]);
  assign nx_c  = uoy_d;
  assign ny_c  = -uox_d;
  assign prx   = sx * nx_c;
  assign pry   = sy * ny_c;

  // products, then dot
  always_ff @(posedge clk) begin
    if (en) begin
      prx_r <= prx;
      pry_r <= pry;
      sx_p  <= sx;
      sy_p  <= sy;
      nx_p  <= nx_c;
      ny_p  <= ny_c;
      dot_r <= DTW'(prx_r) + DTW'(pry_r);
      sx_d  <= sx_p;
      sy_d  <= sy_p;
      nx_d  <= nx_p;
      ny_d  <= ny_p;
    end
  end

  assign dmag = dot_r[DTW-1] ? DTW'(-dot_r) : DTW'(dot_r);
  assign asx  = sx_d[UW-1] ? UW'(-sx_d) : UW'(sx_d);
  assign asy  = sy_d[UW-1] ? UW'(-sy_d) : UW'(sy_d);

  always_comb begin
    ms_n.negx = sx_d[UW-1] ^ dot_r[DTW-1];
    ms_n.negy = sy_d[UW-1] ^ dot_r[DTW-1];
    ms_n.dz   = (dot_r == '0);
    ms_n.ovx  = 1'b0;
    ms_n.ovy  = 1'b0;
    ms_n.nmx  = nx_d[UW-1] ? UW'(-nx_d) : UW'(nx_d);
    ms_n.nmy  = ny_d[UW-1] ? UW'(-ny_d) : UW'(ny_d);
    ms_n.nnx  = nx_d[UW-1];
    ms_n.nny  = ny_d[UW-1];
  end

  // numerators with half-divisor rounding term
  always_ff @(posedge clk) begin
    if (en) begin
      nrx_r  <= (DW'(asx) << (2 * FB)) + DW'(dmag >> 1);
      nry_r  <= (DW'(asy) << (2 * FB)) + DW'(dmag >> 1);
      nden_r <= DW'(dmag);
      ns_r   <= ms_n;
    end
  end

  // quotient range check folded into the side data
  always_comb begin
    ns_nxt     = ns_r;
    ns_nxt.ovx = nrx_r >= (nden_r << NIT);
    ns_nxt.ovy = nry_r >= (nden_r << NIT);
  end

  // range check, then 24 quotient bits one per stage
  always_ff @(posedge clk) begin
    if (en) begin
      dv_den_r[0]   <= nden_r;
      dv_rx_r[0]    <= nrx_r;
      dv_ry_r[0]    <= nry_r;
      dv_qx_r[0]    <= '0;
      dv_qy_r[0]    <= '0;
      dv_s_r[0]     <= ns_nxt;
      for (int t = 0; t < NIT; t++) begin
        if (dv_rx_r[t] >= (dv_den_r[t] << (NIT - 1 - t))) begin
          dv_rx_r[t+1] <= dv_rx_r[t] - (dv_den_r[t] << (NIT - 1 - t));
          dv_qx_r[t+1] <= dv_qx_r[t] | (24'd1 << (NIT - 1 - t));
        end else begin
          dv_rx_r[t+1] <= dv_rx_r[t];
          dv_qx_r[t+1] <= dv_qx_r[t];
        end
        if (dv_ry_r[t] >= (dv_den_r[t] << (NIT - 1 - t))) begin
          dv_ry_r[t+1] <= dv_ry_r[t] - (dv_den_r[t] << (NIT - 1 - t));
          dv_qy_r[t+1] <= dv_qy_r[t] | (24'd1 << (NIT - 1 - t));
        end else begin
          dv_ry_r[t+1] <= dv_ry_r[t];
          dv_qy_r[t+1] <= dv_qy_r[t];
        end
        dv_den_r[t+1] <= dv_den_r[t];
        dv_s_r[t+1]   <= dv_s_r[t];
      end
    end
  end

  // zero dot falls back to the outgoing normal; overflow clamps the magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_s_r[NIT].dz) begin
        mag_x <= 24'(dv_s_r[NIT].nmx);
        mag_y <= 24'(dv_s_r[NIT].nmy);
        neg_x <= dv_s_r[NIT].nnx;
        neg_y <= dv_s_r[NIT].nny;
      end else begin
        mag_x <= dv_s_r[NIT].ovx ? '1 : dv_qx_r[NIT];
        mag_y <= dv_s_r[NIT].ovy ? '1 : dv_qy_r[NIT];
        neg_x <= dv_s_r[NIT].negx;
        neg_y <= dv_s_r[NIT].negy;
      end
    end
  end

endmodule

@@ rtl/thick_line_miter_tessellator.sv @@
// Top level: segment differences, unit vectors, two miter joints and the corner serializer
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------
//  in_     | in  | in_valid / in_ready    | in_data  (in_word_t)
//  out_    | out | out_valid / out_ready  | out_data (out_word_t)
//
// Each segment gives six output words, so the output port sets the segment rate;
// the pipeline itself takes a word per cycle while no stall holds it.
// Reset clears the pipeline valid bits and the serializer state only.
// A stall freezes every pipeline stage together; nothing is dropped or repeated.
module thick_line_miter_tessellator import tlm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int FB  = FRAC_BITS;
  localparam int UW  = FB + 2;
  localparam int UL  = uv_lat(FB);
  localparam int ML  = mt_lat(FB);
  localparam int LAT = 1 + UL + ML;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic [15:0]        w1;
    logic [15:0]        w2;
    logic [23:0]        c1;
    logic [23:0]        c2;
  } pt_t;

  logic                 adv, ser_free, ser_load;
  logic [LAT-1:0]       vld_r;
  logic signed [16:0]   d0x_r, d0y_r, d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [UW-1:0] u0x, u0y, u1x, u1y, u2x, u2y;
  logic [2*UW-1:0]      u1_d;
  logic signed [UW-1:0] nx, ny;
  logic [23:0]          m0mx, m0my, m1mx, m1my;
  logic                 m0nx, m0ny, m1nx, m1ny;
  pt_t                  pt_in, pt_d, pt_r;

  logic               busy_r;
  logic [2:0]         cnt_r;
  logic signed [15:0] npx_r, npy_r, nnx_r, nny_r;
  logic signed [23:0] m0px_r, m0py_r, m0nx_r, m0ny_r;
  logic signed [23:0] m1px_r, m1py_r, m1nx_r, m1ny_r;
  logic               is_end, is_neg;

  // stall control: the whole pipeline moves unless its last word cannot leave
  assign ser_free = !busy_r || (out_ready && cnt_r == LAST_CORNER_IDX);
  assign adv      = !vld_r[LAT-1] || ser_free;
  assign ser_load = vld_r[LAT-1] && ser_free;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // segment direction vectors
  always_ff @(posedge clk) begin
    if (adv) begin
      d0x_r <= 17'(in_data.start_x) - 17'(in_data.before_x);
      d0y_r <= 17'(in_data.start_y) - 17'(in_data.before_y);
      d1x_r <= 17'(in_data.end_x)   - 17'(in_data.start_x);
      d1y_r <= 17'(in_data.end_y)   - 17'(in_data.start_y);
      d2x_r <= 17'(in_data.after_x) - 17'(in_data.end_x);
      d2y_r <= 17'(in_data.after_y) - 17'(in_data.end_y);
    end
  end

  tlm_unit_vec #(.IW(17), .FB(FB)) u_dir0 (
    .clk (clk), .en (adv), .vx (d0x_r), .vy (d0y_r), .ux (u0x), .uy (u0y)
  );
  tlm_unit_vec #(.IW(17), .FB(FB)) u_dir1 (
    .clk (clk), .en (adv), .vx (d1x_r), .vy (d1y_r), .ux (u1x), .uy (u1y)
  );
  tlm_unit_vec #(.IW(17), .FB(FB)) u_dir2 (
    .clk (clk), .en (adv), .vx (d2x_r), .vy (d2y_r), .ux (u2x), .uy (u2y)
  );

  tlm_miter #(.FB(FB)) u_miter0 (
    .clk (clk), .en (adv),
    .ui_x (u0x), .ui_y (u0y), .uo_x (u1x), .uo_y (u1y),
    .mag_x (m0mx), .mag_y (m0my), .neg_x (m0nx), .neg_y (m0ny)
  );
  tlm_miter #(.FB(FB)) u_miter1 (
    .clk (clk), .en (adv),
    .ui_x (u1x), .ui_y (u1y), .uo_x (u2x), .uo_y (u2y),
    .mag_x (m1mx), .mag_y (m1my), .neg_x (m1nx), .neg_y (m1ny)
  );

  // segment normal held until the miters are ready
  tlm_delay #(.W(2 * UW), .D(ML)) u_nrm_dly (
    .clk (clk), .en (adv), .d ({u1x, u1y}), .q (u1_d)
  );
  assign nx = signed'(u1_d[UW-1:0]);
  assign ny = -signed'(u1_d[2*UW-1:UW]);

  // point data rides alongside
  always_comb begin
    pt_in.x1 = in_data.start_x;
    pt_in.y1 = in_data.start_y;
    pt_in.x2 = in_data.end_x;
    pt_in.y2 = in_data.end_y;
    pt_in.w1 = in_data.width_at_start;
    pt_in.w2 = in_data.width_at_end;
    pt_in.c1 = in_data.colour_at_start;
    pt_in.c2 = in_data.colour_at_end;
  end

  tlm_delay #(.W($bits(pt_t)), .D(LAT)) u_pt_dly (
    .clk (clk), .en (adv), .d (pt_in), .q (pt_d)
  );

  // serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (cnt_r == LAST_CORNER_IDX) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  // both signs of normal and miters, saturated at load
  always_ff @(posedge clk) begin
    if (ser_load) begin
      pt_r   <= pt_d;
      npx_r  <= sat16(24'(nx));
      npy_r  <= sat16(24'(ny));
      nnx_r  <= sat16(-(24'(nx)));
      nny_r  <= sat16(-(24'(ny)));
      m0px_r <= sat24(m0nx ? -signed'(26'(m0mx)) : signed'(26'(m0mx)));
      m0py_r <= sat24(m0ny ? -signed'(26'(m0my)) : signed'(26'(m0my)));
      m0nx_r <= sat24(m0nx ? signed'(26'(m0mx)) : -signed'(26'(m0mx)));
      m0ny_r <= sat24(m0ny ? signed'(26'(m0my)) : -signed'(26'(m0my)));
      m1px_r <= sat24(m1nx ? -signed'(26'(m1mx)) : signed'(26'(m1mx)));
      m1py_r <= sat24(m1ny ? -signed'(26'(m1my)) : signed'(26'(m1my)));
      m1nx_r <= sat24(m1nx ? signed'(26'(m1mx)) : -signed'(26'(m1mx)));
      m1ny_r <= sat24(m1ny ? signed'(26'(m1my)) : -signed'(26'(m1my)));
    end
  end

  // corner select
  assign is_end    = AT_END[cnt_r];
  assign is_neg    = NEG_SIDE[cnt_r];
  assign out_valid = busy_r;

  always_comb begin
    out_data.corner_x      = is_end ? pt_r.x2 : pt_r.x1;
    out_data.corner_y      = is_end ? pt_r.y2 : pt_r.y1;
    out_data.side_normal_x = is_neg ? nnx_r : npx_r;
    out_data.side_normal_y = is_neg ? nny_r : npy_r;
    out_data.miter_x       = is_end ? (is_neg ? m1nx_r : m1px_r) : (is_neg ? m0nx_r : m0px_r);
    out_data.miter_y       = is_end ? (is_neg ? m1ny_r : m1py_r) : (is_neg ? m0ny_r : m0py_r);
    out_data.corner_colour = is_end ? pt_r.c2 : pt_r.c1;
    out_data.corner_width  = is_end ? pt_r.w2 : pt_r.w1;
    out_data.last_corner   = (cnt_r == LAST_CORNER_IDX);
  end

  // back-pressure only when the last stage and the serializer are both full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (vld_r[LAT-1] && busy_r))
    else $error("input stalled without a full pipeline tail");

  // a loaded segment starts at its first corner
  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load |=> (out_valid && cnt_r == 3'd0))
    else $error("serializer load did not start at corner zero");

  // after the sixth corner leaves with nothing waiting, the output goes idle
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_corner && !ser_load) |=> !out_valid)
    else $error("output still valid after the last corner");

endmodule
